[rtl/circ_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circumcentre package
// Shared constants and the quotient type that passes from divider to top level.
// ----------------------------------------------------------------------------
package circ_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int OUT_W          = 32;

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] val;
    } t_quot;

endpackage
`default_nettype wire

[rtl/circ_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division, one quotient bit per stage, truncating toward zero and
// clamping the quotient to the signed output range.
// ----------------------------------------------------------------------------
module circ_div
    import circ_pkg::*;
#(
    parameter int NUM_W = 53,
    parameter int DEN_W = 36
) (
    input  wire                     i_clk,
    input  wire signed [NUM_W-1:0]  i_num,
    input  wire signed [DEN_W-1:0]  i_den,
    output t_quot                   o_quot
);

    logic [NUM_W-1:0] r_m   [0:NUM_W];
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [DEN_W-1:0] r_dv  [0:NUM_W];
    logic [OUT_W:0]   r_q   [0:NUM_W];
    logic             r_big [0:NUM_W];
    logic             r_neg [0:NUM_W];
    t_quot            r_out;
    t_quot            n_out;

    always_ff @(posedge i_clk) begin
        r_m[0]   <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_dv[0]  <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        r_rem[0] <= '0;
        r_q[0]   <= '0;
        r_big[0] <= 1'b0;
        r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] n_sh;
        logic [DEN_W:0] n_diff;
        logic           n_ge;

        always_comb begin
            n_sh   = {r_rem[k], r_m[k][NUM_W-1]};
            n_diff = n_sh - {1'b0, r_dv[k]};
            n_ge   = n_sh >= {1'b0, r_dv[k]};
        end

        always_ff @(posedge i_clk) begin
            r_m[k+1]   <= {r_m[k][NUM_W-2:0], 1'b0};
            r_rem[k+1] <= n_ge ? n_diff[DEN_W-1:0] : n_sh[DEN_W-1:0];
            r_dv[k+1]  <= r_dv[k];
            r_q[k+1]   <= {r_q[k][OUT_W-1:0], n_ge};
            r_big[k+1] <= r_big[k] | r_q[k][OUT_W];
            r_neg[k+1] <= r_neg[k];
        end
    end

    always_comb begin
        n_out = '0;
        if (r_neg[NUM_W]) begin
            if (r_big[NUM_W] || r_q[NUM_W] > {1'b0, 1'b1, {(OUT_W-1){1'b0}}}) begin
                n_out.sat = 1'b1;
                n_out.val = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                n_out.val = OUT_W'(-r_q[NUM_W]);
            end
        end else begin
            if (r_big[NUM_W] || r_q[NUM_W] > {2'b00, {(OUT_W-1){1'b1}}}) begin
                n_out.sat = 1'b1;
                n_out.val = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                n_out.val = r_q[NUM_W][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_quot = r_out;

endmodule
`default_nettype wire

[rtl/circumcenter_of_three_points_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circumcentre of three points
// The one-bit-per-stage divider forms most of the pipeline; throughput is one
// request per cycle.
// busy is always low and results cannot be stalled.
// Synchronous active-low reset clears the valid line and the collinear limit.
// ----------------------------------------------------------------------------
module circumcenter_of_three_points_unit
    import circ_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_BITS-1:0]  i_first_x,
    input  wire signed [COORD_BITS-1:0]  i_first_y,
    input  wire signed [COORD_BITS-1:0]  i_second_x,
    input  wire signed [COORD_BITS-1:0]  i_second_y,
    input  wire signed [COORD_BITS-1:0]  i_third_x,
    input  wire signed [COORD_BITS-1:0]  i_third_y,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [31:0]                   i_cfg_data,
    output logic                         o_done,
    output logic signed [OUT_W-1:0]      o_center_x,
    output logic signed [OUT_W-1:0]      o_center_y,
    output logic                         o_collinear,
    output logic                         o_saturated
);

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int ZW = PW + 1;
    localparam int DW = ZW + 1;
    localparam int NW = EW + ZW + 1;
    localparam int LW = DW + 32;
    localparam int DL = NW + 2;

    logic [31:0] r_limit;

    logic                 r1_vld;
    logic signed [EW-1:0] r1_x12, r1_y12, r1_x13, r1_y13;
    logic signed [EW-1:0] r1_sx2, r1_sy2, r1_sx3, r1_sy3, r1_dy32, r1_dx32;

    logic                 r2_vld;
    logic signed [EW-1:0] r2_x12, r2_y12, r2_x13, r2_y13;
    logic signed [PW-1:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;

    logic                 r3_vld;
    logic signed [EW-1:0] r3_x12, r3_y12, r3_x13, r3_y13;
    logic signed [ZW-1:0] r3_z2, r3_z3;
    logic signed [DW-1:0] r3_d;

    logic                    r4_vld, r4_col;
    logic signed [NW-2:0]    r4_a, r4_b, r4_c, r4_e;
    logic signed [DW-1:0]    r4_d;
    logic [DW-1:0]           n_dmag;

    logic                 r5_vld, r5_col;
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic signed [DW-1:0] r5_d;

    logic r_vline [0:DL-1];
    logic r_cline [0:DL-1];

    t_quot w_qx, w_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_vline[0] <= 1'b0;
        end else begin
            r1_vld    <= start;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r_vline[0] <= r5_vld;
        end
    end

    for (genvar i = 1; i < DL; i++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vline[i] <= 1'b0;
            end else begin
                r_vline[i] <= r_vline[i-1];
            end
            r_cline[i] <= r_cline[i-1];
        end
    end

    always_comb begin
        n_dmag = r3_d[DW-1] ? DW'(-r3_d) : DW'(r3_d);
    end

    always_ff @(posedge i_clk) begin
        r1_x12  <= EW'(i_second_x) - EW'(i_first_x);
        r1_y12  <= EW'(i_second_y) - EW'(i_first_y);
        r1_x13  <= EW'(i_third_x) - EW'(i_first_x);
        r1_y13  <= EW'(i_third_y) - EW'(i_first_y);
        r1_sx2  <= EW'(i_first_x) + EW'(i_second_x);
        r1_sy2  <= EW'(i_first_y) + EW'(i_second_y);
        r1_sx3  <= EW'(i_first_x) + EW'(i_third_x);
        r1_sy3  <= EW'(i_first_y) + EW'(i_third_y);
        r1_dy32 <= EW'(i_third_y) - EW'(i_second_y);
        r1_dx32 <= EW'(i_third_x) - EW'(i_second_x);

        r2_x12 <= r1_x12;
        r2_y12 <= r1_y12;
        r2_x13 <= r1_x13;
        r2_y13 <= r1_y13;
        r2_p1  <= r1_x12 * r1_sx2;
        r2_p2  <= r1_y12 * r1_sy2;
        r2_p3  <= r1_x13 * r1_sx3;
        r2_p4  <= r1_y13 * r1_sy3;
        r2_p5  <= r1_x12 * r1_dy32;
        r2_p6  <= r1_y12 * r1_dx32;

        r3_x12 <= r2_x12;
        r3_y12 <= r2_y12;
        r3_x13 <= r2_x13;
        r3_y13 <= r2_y13;
        r3_z2  <= ZW'(r2_p1) + ZW'(r2_p2);
        r3_z3  <= ZW'(r2_p3) + ZW'(r2_p4);
        r3_d   <= {ZW'(r2_p5) - ZW'(r2_p6), 1'b0};

        r4_a   <= r3_y13 * r3_z2;
        r4_b   <= r3_y12 * r3_z3;
        r4_c   <= r3_x12 * r3_z3;
        r4_e   <= r3_x13 * r3_z2;
        r4_d   <= r3_d;
        r4_col <= LW'(n_dmag) <= LW'(r_limit);

        r5_nx  <= NW'(r4_a) - NW'(r4_b);
        r5_ny  <= NW'(r4_c) - NW'(r4_e);
        r5_d   <= r4_d;
        r5_col <= r4_col;

        r_cline[0] <= r5_col;
    end

    circ_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_num  (r5_nx),
        .i_den  (r5_d),
        .o_quot (w_qx)
    );

    circ_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_num  (r5_ny),
        .i_den  (r5_d),
        .o_quot (w_qy)
    );

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_vline[DL-1];
    assign o_collinear = r_cline[DL-1];
    assign o_center_x  = r_cline[DL-1] ? '0 : w_qx.val;
    assign o_center_y  = r_cline[DL-1] ? '0 : w_qy.val;
    assign o_saturated = !r_cline[DL-1] && (w_qx.sat || w_qy.sat);

endmodule
`default_nettype wire

[rtl/circ_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circumcentre port checker
// Watches the ports of the top level for result timing and flag consistency.
// ----------------------------------------------------------------------------
module circ_checker
    import circ_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     start,
    input wire                     busy,
    input wire                     o_done,
    input wire signed [OUT_W-1:0]  o_center_x,
    input wire signed [OUT_W-1:0]  o_center_y,
    input wire                     o_collinear,
    input wire                     o_saturated
);

    localparam int LAT = 3 * COORD_BITS + 12;

    a_done_follows_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("Result without a matching request.");

    a_collinear_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_collinear |-> o_center_x == 0 && o_center_y == 0 && !o_saturated)
        else $error("Collinear result carries a non-zero centre.");

    a_sat_extreme : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |->
            o_center_x == {1'b1, {(OUT_W-1){1'b0}}} || o_center_x == {1'b0, {(OUT_W-1){1'b1}}}
            || o_center_y == {1'b1, {(OUT_W-1){1'b0}}}
            || o_center_y == {1'b0, {(OUT_W-1){1'b1}}})
        else $error("Saturated result without a clamped coordinate.");

    a_request_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !busy)
        else $error("Unit became busy after taking a request.");

endmodule

bind circumcenter_of_three_points_unit circ_checker #(
    .COORD_BITS (COORD_BITS)
) u_circ_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_center_x  (o_center_x),
    .o_center_y  (o_center_y),
    .o_collinear (o_collinear),
    .o_saturated (o_saturated)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcentre unit testbench
// Drives triangles through the command port in random bursts, writes the
// collinear limit between phases, and checks each centre against a predictor
// built from exact wide integer arithmetic or against a typed expected value.
// ----------------------------------------------------------------------------
module testbench;
    import circ_pkg::*;

    localparam int CW          = 16;
    localparam int DRAIN_WAIT  = 3 * CW + 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    coll;
        logic                    sat;
    } centre_t;

    typedef struct {
        logic signed [CW-1:0] p[6];
        logic                 typed;
        centre_t              want;
    } triangle_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [CW-1:0]    pt[6];
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [31:0]             i_cfg_data;
    logic                    o_done;
    logic signed [OUT_W-1:0] o_center_x;
    logic signed [OUT_W-1:0] o_center_y;
    logic                    o_collinear;
    logic                    o_saturated;

    centre_t                 centre_q[$];
    logic [31:0]             limit_shadow = '0;
    logic                    typed_pending;
    centre_t                 typed_centre;
    int                      fail_count = 0;
    int                      cycle_count = 0;
    int                      burst_left;

    circumcenter_of_three_points_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_first_x   (pt[0]),
        .i_first_y   (pt[1]),
        .i_second_x  (pt[2]),
        .i_second_y  (pt[3]),
        .i_third_x   (pt[4]),
        .i_third_y   (pt[5]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_collinear (o_collinear),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [OUT_W-1:0] clamp_quotient(logic signed [127:0] num,
                                                        longint den, ref logic sat);
        logic          neg;
        logic [127:0]  un;
        logic [127:0]  ud;
        logic [127:0]  q;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? 128'(-den) : 128'(den);
        q   = un / ud;
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(128'd0 - q);
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return 32'(q);
    endfunction

    function automatic centre_t circumcentre(logic signed [CW-1:0] p[6], logic [31:0] lim);
        longint            x1, y1, x2, y2, x3, y3;
        longint            x12, y12, x13, y13, z2, z3, d;
        logic [63:0]       dmag;
        logic signed [127:0] w_x12, w_y12, w_x13, w_y13, w_z2, w_z3;
        logic              sat;
        centre_t           r;
        x1 = longint'(p[0]); y1 = longint'(p[1]);
        x2 = longint'(p[2]); y2 = longint'(p[3]);
        x3 = longint'(p[4]); y3 = longint'(p[5]);
        x12 = x2 - x1; y12 = y2 - y1;
        x13 = x3 - x1; y13 = y3 - y1;
        z2 = x12 * (x1 + x2) + y12 * (y1 + y2);
        z3 = x13 * (x1 + x3) + y13 * (y1 + y3);
        d  = 2 * (x12 * (y3 - y2) - y12 * (x3 - x2));
        dmag = (d < 0) ? 64'(-d) : 64'(d);
        r = '0;
        if (dmag <= 64'(lim)) begin
            r.coll = 1'b1;
            return r;
        end
        w_x12 = 128'(x12); w_y12 = 128'(y12); w_x13 = 128'(x13); w_y13 = 128'(y13);
        w_z2  = 128'(z2);  w_z3  = 128'(z3);
        sat  = 1'b0;
        r.cx = clamp_quotient(w_y13 * w_z2 - w_y12 * w_z3, d, sat);
        r.cy = clamp_quotient(w_x12 * w_z3 - w_x13 * w_z2, d, sat);
        r.sat = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        centre_t got;
        centre_t exp_c;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                limit_shadow <= i_cfg_data;
            if (start && !busy) begin
                if (typed_pending) begin
                    centre_q.push_back(typed_centre);
                end else begin
                    centre_q.push_back(circumcentre(pt, limit_shadow));
                end
            end
            if (o_done) begin
                got = {o_center_x, o_center_y, o_collinear, o_saturated};
                if (centre_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    exp_c = centre_q.pop_front();
                    if (got.cx !== exp_c.cx) begin
                        $display("%0t: center_x expected %h actual %h", $time, exp_c.cx, got.cx);
                        fail_count++;
                    end
                    if (got.cy !== exp_c.cy) begin
                        $display("%0t: center_y expected %h actual %h", $time, exp_c.cy, got.cy);
                        fail_count++;
                    end
                    if (got.coll !== exp_c.coll) begin
                        $display("%0t: collinear expected %b actual %b", $time, exp_c.coll,
                                 got.coll);
                        fail_count++;
                    end
                    if (got.sat !== exp_c.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time, exp_c.sat,
                                 got.sat);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic send_triangle(logic signed [CW-1:0] p[6]);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        start = 1'b1;
        pt = p;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        typed_pending = 1'b0;
        burst_left--;
        if ($urandom_range(0, 5) == 0 && burst_left > 0)
            burst_left = 0;
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (centre_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic triangle_row_t make_row(int p0, int p1, int p2, int p3, int p4, int p5,
                                               logic typed, centre_t want);
        triangle_row_t r;
        r.p[0] = CW'(p0); r.p[1] = CW'(p1); r.p[2] = CW'(p2);
        r.p[3] = CW'(p3); r.p[4] = CW'(p4); r.p[5] = CW'(p5);
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic random_triangle(output logic signed [CW-1:0] p[6]);
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            for (int i = 0; i < 6; i++) p[i] = CW'($urandom());
        end else if (kind < 7) begin
            for (int i = 0; i < 6; i++) p[i] = CW'($urandom_range(0, 2047) - 1024);
        end else begin
            // Nearly collinear points: small cross products and large centres.
            for (int i = 0; i < 4; i++) p[i] = CW'($urandom());
            k = $urandom_range(0, 6) - 3;
            p[4] = CW'(p[0] + k * (p[2] - p[0]) + $urandom_range(0, 4) - 2);
            p[5] = CW'(p[1] + k * (p[3] - p[1]) + $urandom_range(0, 4) - 2);
        end
    endtask

    initial begin
        triangle_row_t        rows[$];
        logic signed [CW-1:0] p[6];
        logic [31:0]          limits[6];
        start         = 1'b0;
        for (int i = 0; i < 6; i++) pt[i] = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        typed_pending = 1'b0;
        typed_centre  = '0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b1, 1'b0}));
        rows.push_back(make_row(0, 0, 512, 0, 0, 512, 1'b1, '{256, 256, 1'b0, 1'b0}));
        rows.push_back(make_row(-32768, -32768, -32768, -32768, 32767, 32767, 1'b1,
                                '{0, 0, 1'b1, 1'b0}));
        rows.push_back(make_row(-32768, -32768, 32767, -32768, -32768, 32767, 1'b0, '0));
        rows.push_back(make_row(32767, 32767, -32768, 32767, 32767, -32768, 1'b0, '0));
        rows.push_back(make_row(-32768, -32768, 32767, 32767, 32767, 32766, 1'b0, '0));
        rows.push_back(make_row(-32768, -32768, 32767, 32767, 32766, 32767, 1'b0, '0));
        rows.push_back(make_row(0, 0, 1, 0, 0, 1, 1'b0, '0));
        rows.push_back(make_row(-1, -1, 1, 1, 2, 2, 1'b1, '{0, 0, 1'b1, 1'b0}));
        rows.push_back(make_row(100, -200, -300, 400, 500, 600, 1'b0, '0));
        rows.push_back(make_row(-32768, 0, 32767, 0, 0, 1, 1'b0, '0));
        rows.push_back(make_row(0, -32768, 0, 32767, 1, 0, 1'b0, '0));

        write_limit(32'd0);
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                typed_pending = 1'b1;
                typed_centre  = rows[i].want;
            end
            send_triangle(rows[i].p);
        end
        drain_results();

        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = 32'h0001_0000;
        limits[4] = $urandom();
        limits[5] = 32'd0;
        foreach (limits[ph]) begin
            write_limit(limits[ph]);
            for (int n = 0; n < 256; n++) begin
                random_triangle(p);
                send_triangle(p);
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
